FILE: rtl/pmq_pkg.sv
// Shared types, codes and defaults of the priority message queue.
package pmq_pkg;

   localparam int QueueDepthDefault      = 16;
   localparam int MaxMessageBytesDefault = 256;
   localparam int PriorityLimitDefault   = 32768;
   localparam int TagBitsDefault         = 16;

   localparam logic [7:0] SignalTop = 8'd64;

   localparam logic [4:0] MaxMessagesReset = 5'd10;
   localparam logic [8:0] MessageSizeReset = 9'd256;

   typedef enum logic [1:0] {
      KIND_SEND          = 2'd0,
      KIND_RECEIVE       = 2'd1,
      KIND_NOTIFY_REG    = 2'd2,
      KIND_NOTIFY_CANCEL = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_ACCESS  = 3'd1,
      ST_INVALID     = 3'd2,
      ST_SIZE_ERROR  = 3'd3,
      ST_WOULD_BLOCK = 3'd4,
      ST_BUSY        = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ACCESS_RECEIVE_ONLY = 2'd0,
      ACCESS_SEND_ONLY    = 2'd1,
      ACCESS_BOTH         = 2'd2
   } access_type;

   typedef enum logic [1:0] {
      REG_MAX_MESSAGES = 2'd0,
      REG_MESSAGE_SIZE = 2'd1,
      REG_ACCESS_MODE  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [4:0] max_messages;
      logic [8:0] length_limit;
      logic [1:0] access_mode;
   } cfg_type;

   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctl_type;

endpackage

FILE: rtl/pmq_cell.sv
// One entry of the sorted queue: holds a message and shifts it along the row.
module pmq_cell #(
   parameter int LEN_BITS  = 9,
   parameter int PRIO_BITS = 15,
   parameter int TAG_BITS  = 16
) (
   input  logic                  clock,
   input  pmq_pkg::cell_ctl_type ctl,
   input  logic                  occupied,
   input  logic                  left_keep,
   input  logic [LEN_BITS-1:0]   new_len,
   input  logic [PRIO_BITS-1:0]  new_prio,
   input  logic [TAG_BITS-1:0]   new_tag,
   input  logic [LEN_BITS-1:0]   left_len,
   input  logic [PRIO_BITS-1:0]  left_prio,
   input  logic [TAG_BITS-1:0]   left_tag,
   input  logic [LEN_BITS-1:0]   right_len,
   input  logic [PRIO_BITS-1:0]  right_prio,
   input  logic [TAG_BITS-1:0]   right_tag,
   output logic                  keep,
   output logic [LEN_BITS-1:0]   len_q,
   output logic [PRIO_BITS-1:0]  prio_q,
   output logic [TAG_BITS-1:0]   tag_q
);

   logic [LEN_BITS-1:0]  len_ff;
   logic [PRIO_BITS-1:0] prio_ff;
   logic [TAG_BITS-1:0]  tag_ff;

   // An entry of equal or higher priority stays ahead of the new message.
   assign keep = occupied && (prio_ff >= new_prio);

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         if (!keep) begin
            if (left_keep) begin
               len_ff  <= new_len;
               prio_ff <= new_prio;
               tag_ff  <= new_tag;
            end else begin
               len_ff  <= left_len;
               prio_ff <= left_prio;
               tag_ff  <= left_tag;
            end
         end
      end else if (ctl.pop) begin
         len_ff  <= right_len;
         prio_ff <= right_prio;
         tag_ff  <= right_tag;
      end
   end

   assign len_q  = len_ff;
   assign prio_q = prio_ff;
   assign tag_q  = tag_ff;

endmodule

FILE: rtl/pmq_csr.sv
// Configuration registers of the priority message queue behind an APB-style port.
module pmq_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output pmq_pkg::cfg_type cfg
);

   logic [4:0] max_messages_ff;
   logic [8:0] length_limit_ff;
   logic [1:0] access_mode_ff;
   logic       write_en;
   pmq_pkg::reg_index_type index;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;
   assign index    = pmq_pkg::reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_messages_ff <= pmq_pkg::MaxMessagesReset;
         length_limit_ff <= pmq_pkg::MessageSizeReset;
         access_mode_ff  <= pmq_pkg::ACCESS_BOTH;
      end else if (write_en) begin
         unique case (index)
            pmq_pkg::REG_MAX_MESSAGES: max_messages_ff <= pwdata[4:0];
            pmq_pkg::REG_MESSAGE_SIZE: length_limit_ff <= pwdata[8:0];
            pmq_pkg::REG_ACCESS_MODE:  access_mode_ff  <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         pmq_pkg::REG_MAX_MESSAGES: prdata = 32'(max_messages_ff);
         pmq_pkg::REG_MESSAGE_SIZE: prdata = 32'(length_limit_ff);
         pmq_pkg::REG_ACCESS_MODE:  prdata = 32'(access_mode_ff);
         default:                   prdata = 32'd0;
      endcase
   end

   assign cfg.max_messages = max_messages_ff;
   assign cfg.length_limit = length_limit_ff;
   assign cfg.access_mode  = access_mode_ff;

endmodule

FILE: rtl/priority_message_queue.sv
// Priority message queue top level: request decode, checks, notification and results.
//
// One request is taken in every clock cycle: busy stays low, and the result of an
// accepted request is registered and shown on the rsp_ ports, with rsp_strobe high
// for a single cycle. The receiver cannot hold results off. Messages
// sit in a row of QUEUE_DEPTH cells kept in priority order; on a send every cell
// compares its priority with the new one in the same cycle and the row shifts
// back by one behind the insertion point, on a receive the whole row shifts
// forward by one. Occupancy follows from the message count, so there is no
// clearing pass after reset.
module priority_message_queue #(
   parameter int QUEUE_DEPTH       = pmq_pkg::QueueDepthDefault,
   parameter int MAX_MESSAGE_BYTES = pmq_pkg::MaxMessageBytesDefault,
   parameter int PRIORITY_LIMIT    = pmq_pkg::PriorityLimitDefault,
   parameter int TAG_BITS          = pmq_pkg::TagBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_length,
   input  logic [15:0] req_priority_req,
   input  logic [15:0] req_payload_tag,
   input  logic [30:0] req_requester_id,
   input  logic        req_signal_mode,
   input  logic [7:0]  req_signal_number,
   input  logic [63:0] req_signal_value,
   input  logic        req_owner_gone,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [8:0]  rsp_out_length,
   output logic [14:0] rsp_out_priority,
   output logic [15:0] rsp_out_tag,
   output logic [4:0]  rsp_message_count,
   output logic        rsp_notify_fire,
   output logic [30:0] rsp_notify_target,
   output logic [7:0]  rsp_notify_signal,
   output logic [63:0] rsp_notify_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int LEN_BITS   = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int PRIO_BITS  = $clog2(PRIORITY_LIMIT);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   pmq_pkg::cfg_type      cfg;
   pmq_pkg::cell_ctl_type ctl;
   pmq_pkg::kind_type     kind;
   pmq_pkg::status_type   status;

   logic accept;

   logic [COUNT_BITS-1:0] held_count_ff, held_count_in;
   logic [30:0]           watcher_id_ff, watcher_id_in;
   logic                  watcher_mode_ff, watcher_mode_in;
   logic [7:0]            watcher_signal_ff, watcher_signal_in;
   logic [63:0]           watcher_value_ff, watcher_value_in;

   logic        rsp_strobe_ff;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [8:0]  rsp_out_length_ff, rsp_out_length_in;
   logic [14:0] rsp_out_priority_ff, rsp_out_priority_in;
   logic [15:0] rsp_out_tag_ff, rsp_out_tag_in;
   logic [4:0]  rsp_message_count_ff;
   logic        rsp_notify_fire_ff, rsp_notify_fire_in;
   logic [30:0] rsp_notify_target_ff, rsp_notify_target_in;
   logic [7:0]  rsp_notify_signal_ff, rsp_notify_signal_in;
   logic [63:0] rsp_notify_data_ff, rsp_notify_data_in;

   logic [31:0] capacity_w, size_limit_w, held_w, held_in_w;
   logic [31:0] len_w, prio_w, tag_w;
   logic [31:0] head_len_w, head_prio_w, head_tag_w;
   logic        held_empty;

   logic [LEN_BITS-1:0]  new_len;
   logic [PRIO_BITS-1:0] new_prio;
   logic [TAG_BITS-1:0]  new_tag;

   logic [QUEUE_DEPTH-1:0] occupied;
   logic [QUEUE_DEPTH-1:0] keep;
   logic [LEN_BITS-1:0]    len_q  [QUEUE_DEPTH];
   logic [PRIO_BITS-1:0]   prio_q [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]    tag_q  [QUEUE_DEPTH];

   pmq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign kind   = pmq_pkg::kind_type'(req_kind);

   assign len_w    = 32'(req_length);
   assign prio_w   = 32'(req_priority_req);
   assign tag_w    = 32'(req_payload_tag);
   assign new_len  = len_w[LEN_BITS-1:0];
   assign new_prio = prio_w[PRIO_BITS-1:0];
   assign new_tag  = tag_w[TAG_BITS-1:0];

   assign held_w     = 32'(held_count_ff);
   assign held_empty = (held_count_ff == '0);
   assign capacity_w = (32'(cfg.max_messages) > 32'(QUEUE_DEPTH)) ?
                       32'(QUEUE_DEPTH) : 32'(cfg.max_messages);
   assign size_limit_w = (32'(cfg.length_limit) > 32'(MAX_MESSAGE_BYTES)) ?
                         32'(MAX_MESSAGE_BYTES) : 32'(cfg.length_limit);

   generate
      for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         logic                 left_keep;
         logic [LEN_BITS-1:0]  left_len, right_len;
         logic [PRIO_BITS-1:0] left_prio, right_prio;
         logic [TAG_BITS-1:0]  left_tag, right_tag;

         assign occupied[i] = (32'(i) < held_w);

         if (i == 0) begin : g_first
            // The head has nobody ahead of it, so it takes the new message itself.
            assign left_keep = 1'b1;
            assign left_len  = new_len;
            assign left_prio = new_prio;
            assign left_tag  = new_tag;
         end else begin : g_inner
            assign left_keep = keep[i-1];
            assign left_len  = len_q[i-1];
            assign left_prio = prio_q[i-1];
            assign left_tag  = tag_q[i-1];
         end

         if (i == QUEUE_DEPTH - 1) begin : g_last
            assign right_len  = len_q[i];
            assign right_prio = prio_q[i];
            assign right_tag  = tag_q[i];
         end else begin : g_body
            assign right_len  = len_q[i+1];
            assign right_prio = prio_q[i+1];
            assign right_tag  = tag_q[i+1];
         end

         pmq_cell #(
            .LEN_BITS  (LEN_BITS),
            .PRIO_BITS (PRIO_BITS),
            .TAG_BITS  (TAG_BITS)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occupied   (occupied[i]),
            .left_keep  (left_keep),
            .new_len    (new_len),
            .new_prio   (new_prio),
            .new_tag    (new_tag),
            .left_len   (left_len),
            .left_prio  (left_prio),
            .left_tag   (left_tag),
            .right_len  (right_len),
            .right_prio (right_prio),
            .right_tag  (right_tag),
            .keep       (keep[i]),
            .len_q      (len_q[i]),
            .prio_q     (prio_q[i]),
            .tag_q      (tag_q[i])
         );
      end
   endgenerate

   assign head_len_w  = 32'(len_q[0]);
   assign head_prio_w = 32'(prio_q[0]);
   assign head_tag_w  = 32'(tag_q[0]);

   always_comb begin
      status               = pmq_pkg::ST_OK;
      ctl                  = '0;
      held_count_in        = held_count_ff;
      watcher_id_in        = watcher_id_ff;
      watcher_mode_in      = watcher_mode_ff;
      watcher_signal_in    = watcher_signal_ff;
      watcher_value_in     = watcher_value_ff;
      rsp_out_length_in    = '0;
      rsp_out_priority_in  = '0;
      rsp_out_tag_in       = '0;
      rsp_notify_fire_in   = 1'b0;
      rsp_notify_target_in = '0;
      rsp_notify_signal_in = '0;
      rsp_notify_data_in   = '0;

      if (accept) begin
         unique case (kind)
            pmq_pkg::KIND_SEND: begin
               if (prio_w >= 32'(PRIORITY_LIMIT)) begin
                  status = pmq_pkg::ST_INVALID;
               end else if (cfg.access_mode == pmq_pkg::ACCESS_RECEIVE_ONLY) begin
                  status = pmq_pkg::ST_BAD_ACCESS;
               end else if (len_w > size_limit_w) begin
                  status = pmq_pkg::ST_SIZE_ERROR;
               end else if (held_w >= capacity_w) begin
                  status = pmq_pkg::ST_WOULD_BLOCK;
               end else begin
                  ctl.push      = 1'b1;
                  held_count_in = held_count_ff + COUNT_BITS'(1);
                  // The first message into an empty queue consumes the registration.
                  if (held_empty && (watcher_id_ff != '0)) begin
                     watcher_id_in = '0;
                     if (watcher_mode_ff) begin
                        rsp_notify_fire_in   = 1'b1;
                        rsp_notify_target_in = watcher_id_ff;
                        rsp_notify_signal_in = watcher_signal_ff;
                        rsp_notify_data_in   = watcher_value_ff;
                     end
                  end
               end
            end
            pmq_pkg::KIND_RECEIVE: begin
               if (cfg.access_mode == pmq_pkg::ACCESS_SEND_ONLY) begin
                  status = pmq_pkg::ST_BAD_ACCESS;
               end else if (len_w < size_limit_w) begin
                  status = pmq_pkg::ST_SIZE_ERROR;
               end else if (held_empty) begin
                  status = pmq_pkg::ST_WOULD_BLOCK;
               end else begin
                  ctl.pop             = 1'b1;
                  held_count_in       = held_count_ff - COUNT_BITS'(1);
                  rsp_out_length_in   = head_len_w[8:0];
                  rsp_out_priority_in = head_prio_w[14:0];
                  rsp_out_tag_in      = head_tag_w[15:0];
               end
            end
            pmq_pkg::KIND_NOTIFY_REG: begin
               if (req_signal_mode && ((req_signal_number == 8'd0) ||
                                       (req_signal_number > pmq_pkg::SignalTop))) begin
                  status = pmq_pkg::ST_INVALID;
               end else if ((watcher_id_ff != '0) && !req_owner_gone) begin
                  status = pmq_pkg::ST_BUSY;
               end else begin
                  watcher_id_in     = req_requester_id;
                  watcher_mode_in   = req_signal_mode;
                  watcher_signal_in = req_signal_number;
                  watcher_value_in  = req_signal_value;
                  // Messages already waiting: drop the registration, firing at once in signal mode.
                  if (!held_empty) begin
                     watcher_id_in = '0;
                     if (req_signal_mode) begin
                        rsp_notify_fire_in   = 1'b1;
                        rsp_notify_target_in = req_requester_id;
                        rsp_notify_signal_in = req_signal_number;
                        rsp_notify_data_in   = req_signal_value;
                     end
                  end
               end
            end
            pmq_pkg::KIND_NOTIFY_CANCEL: begin
               if (watcher_id_ff == req_requester_id) begin
                  watcher_id_in = '0;
               end
            end
            default: ;
         endcase
      end
      rsp_status_in = status;
   end

   assign held_in_w = 32'(held_count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff     <= '0;
         watcher_id_ff     <= '0;
         watcher_mode_ff   <= 1'b0;
         watcher_signal_ff <= '0;
         watcher_value_ff  <= '0;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         held_count_ff     <= held_count_in;
         watcher_id_ff     <= watcher_id_in;
         watcher_mode_ff   <= watcher_mode_in;
         watcher_signal_ff <= watcher_signal_in;
         watcher_value_ff  <= watcher_value_in;
         rsp_strobe_ff     <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff        <= rsp_status_in;
         rsp_out_length_ff    <= rsp_out_length_in;
         rsp_out_priority_ff  <= rsp_out_priority_in;
         rsp_out_tag_ff       <= rsp_out_tag_in;
         rsp_message_count_ff <= held_in_w[4:0];
         rsp_notify_fire_ff   <= rsp_notify_fire_in;
         rsp_notify_target_ff <= rsp_notify_target_in;
         rsp_notify_signal_ff <= rsp_notify_signal_in;
         rsp_notify_data_ff   <= rsp_notify_data_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_length    = rsp_out_length_ff;
   assign rsp_out_priority  = rsp_out_priority_ff;
   assign rsp_out_tag       = rsp_out_tag_ff;
   assign rsp_message_count = rsp_message_count_ff;
   assign rsp_notify_fire   = rsp_notify_fire_ff;
   assign rsp_notify_target = rsp_notify_target_ff;
   assign rsp_notify_signal = rsp_notify_signal_ff;
   assign rsp_notify_data   = rsp_notify_data_ff;

`ifndef NO_ASSERTIONS
   a_held_bounded: assert property (@(posedge clock) disable iff (reset)
      held_w <= 32'(QUEUE_DEPTH))
      else $error("message count beyond queue depth");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted request gave no result strobe");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!reset && !accept) |=> !rsp_strobe)
      else $error("result strobe without an accepted request");

   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (!reset && !accept) |=> $stable(held_count_ff))
      else $error("message count changed with no request");

   a_fire_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_notify_fire) |-> (rsp_status == pmq_pkg::ST_OK))
      else $error("notification fired on a failed request");
`endif

endmodule

FILE: dv/pmq_result_checker.sv
// Result checker for the priority message queue: predicts every result and compares it.
module pmq_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_length,
   input  logic [15:0] req_priority_req,
   input  logic [15:0] req_payload_tag,
   input  logic [30:0] req_requester_id,
   input  logic        req_signal_mode,
   input  logic [7:0]  req_signal_number,
   input  logic [63:0] req_signal_value,
   input  logic        req_owner_gone,
   input  logic        rsp_strobe,
   input  logic [2:0]  rsp_status,
   input  logic [8:0]  rsp_out_length,
   input  logic [14:0] rsp_out_priority,
   input  logic [15:0] rsp_out_tag,
   input  logic [4:0]  rsp_message_count,
   input  logic        rsp_notify_fire,
   input  logic [30:0] rsp_notify_target,
   input  logic [7:0]  rsp_notify_signal,
   input  logic [63:0] rsp_notify_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output int          mismatches,
   output int          outstanding
);

   typedef struct {
      logic [2:0]  status;
      logic [8:0]  msg_len;
      logic [14:0] msg_prio;
      logic [15:0] msg_tag;
      logic [4:0]  count;
      logic        fire;
      logic [30:0] target;
      logic [7:0]  signal_no;
      logic [63:0] value;
   } outcome_type;

   logic [8:0]  slot_len  [pmq_pkg::QueueDepthDefault];
   logic [14:0] slot_prio [pmq_pkg::QueueDepthDefault];
   logic [15:0] slot_tag  [pmq_pkg::QueueDepthDefault];
   int          held;
   logic [30:0] watcher_id;
   logic        watcher_mode;
   logic [7:0]  watcher_sig;
   logic [63:0] watcher_val;
   pmq_pkg::cfg_type cfg;

   outcome_type awaited_results[$];
   outcome_type oldest;
   int          mismatch_count = 0;

   assign mismatches = mismatch_count;

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] seen,
                                input logic [63:0] want);
      if (seen !== want)
         report_mismatch($sformatf("%s got %0h, want %0h", name, seen, want));
   endtask

   // Applies one request to the shadow queue and returns the result it should give.
   function automatic outcome_type serve_request(
      input logic [1:0] kind, input logic [15:0] len, input logic [15:0] prio,
      input logic [15:0] tag, input logic [30:0] id, input logic smode,
      input logic [7:0] snum, input logic [63:0] sval, input logic gone);
      outcome_type res;
      int       cap;
      int       size_lim;
      int       pos;
      int       i;
      bit       first_message;
      res = '{default: '0};
      res.status = pmq_pkg::ST_OK;
      cap = (cfg.max_messages > pmq_pkg::QueueDepthDefault) ? pmq_pkg::QueueDepthDefault
                                                             : int'(cfg.max_messages);
      size_lim = (cfg.length_limit > pmq_pkg::MaxMessageBytesDefault)
                 ? pmq_pkg::MaxMessageBytesDefault : int'(cfg.length_limit);
      case (kind)
         pmq_pkg::KIND_SEND: begin
            if (prio >= pmq_pkg::PriorityLimitDefault) res.status = pmq_pkg::ST_INVALID;
            else if (cfg.access_mode == pmq_pkg::ACCESS_RECEIVE_ONLY)
               res.status = pmq_pkg::ST_BAD_ACCESS;
            else if (len > size_lim) res.status = pmq_pkg::ST_SIZE_ERROR;
            else if (held >= cap) res.status = pmq_pkg::ST_WOULD_BLOCK;
            else begin
               first_message = (held == 0);
               pos = held;
               // Equal priorities stay ahead, so ties leave in arrival order.
               while (pos > 0 && slot_prio[pos-1] < prio[14:0]) begin
                  slot_len[pos]  = slot_len[pos-1];
                  slot_prio[pos] = slot_prio[pos-1];
                  slot_tag[pos]  = slot_tag[pos-1];
                  pos--;
               end
               slot_len[pos]  = len[8:0];
               slot_prio[pos] = prio[14:0];
               slot_tag[pos]  = tag;
               held++;
               if (first_message && watcher_id != '0) begin
                  if (watcher_mode) begin
                     res.fire      = 1'b1;
                     res.target    = watcher_id;
                     res.signal_no = watcher_sig;
                     res.value     = watcher_val;
                  end
                  watcher_id = '0;
               end
            end
         end
         pmq_pkg::KIND_RECEIVE: begin
            if (cfg.access_mode == pmq_pkg::ACCESS_SEND_ONLY)
               res.status = pmq_pkg::ST_BAD_ACCESS;
            else if (len < size_lim) res.status = pmq_pkg::ST_SIZE_ERROR;
            else if (held == 0) res.status = pmq_pkg::ST_WOULD_BLOCK;
            else begin
               res.msg_len  = slot_len[0];
               res.msg_prio = slot_prio[0];
               res.msg_tag  = slot_tag[0];
               for (i = 1; i < held; i++) begin
                  slot_len[i-1]  = slot_len[i];
                  slot_prio[i-1] = slot_prio[i];
                  slot_tag[i-1]  = slot_tag[i];
               end
               held--;
            end
         end
         pmq_pkg::KIND_NOTIFY_REG: begin
            if (smode && (snum == '0 || snum > pmq_pkg::SignalTop))
               res.status = pmq_pkg::ST_INVALID;
            else if (watcher_id != '0 && !gone) res.status = pmq_pkg::ST_BUSY;
            else begin
               watcher_id   = id;
               watcher_mode = smode;
               watcher_sig  = snum;
               watcher_val  = sval;
               // With messages already waiting the registration is spent at once.
               if (held != 0) begin
                  watcher_id = '0;
                  if (smode) begin
                     res.fire      = 1'b1;
                     res.target    = id;
                     res.signal_no = snum;
                     res.value     = sval;
                  end
               end
            end
         end
         default: begin
            if (watcher_id == id) watcher_id = '0;
         end
      endcase
      res.count = 5'(held);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held             = 0;
         watcher_id       = '0;
         watcher_mode     = 1'b0;
         watcher_sig      = '0;
         watcher_val      = '0;
         cfg.max_messages = pmq_pkg::MaxMessagesReset;
         cfg.length_limit = pmq_pkg::MessageSizeReset;
         cfg.access_mode  = pmq_pkg::ACCESS_BOTH;
         awaited_results.delete();
         outstanding <= 0;
      end else begin
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result strobed with no request outstanding");
            end else begin
               oldest = awaited_results.pop_front();
               compare_field("status", rsp_status, oldest.status);
               compare_field("out_length", rsp_out_length, oldest.msg_len);
               compare_field("out_priority", rsp_out_priority, oldest.msg_prio);
               compare_field("out_tag", rsp_out_tag, oldest.msg_tag);
               compare_field("message_count", rsp_message_count, oldest.count);
               compare_field("notify_fire", rsp_notify_fire, oldest.fire);
               compare_field("notify_target", rsp_notify_target, oldest.target);
               compare_field("notify_signal", rsp_notify_signal, oldest.signal_no);
               compare_field("notify_data", rsp_notify_data, oldest.value);
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               pmq_pkg::REG_MAX_MESSAGES: cfg.max_messages = pwdata[4:0];
               pmq_pkg::REG_MESSAGE_SIZE: cfg.length_limit = pwdata[8:0];
               pmq_pkg::REG_ACCESS_MODE:  cfg.access_mode  = pwdata[1:0];
               default: ;
            endcase
         end
         if (start && !busy)
            awaited_results.push_back(serve_request(
               req_kind, req_length, req_priority_req, req_payload_tag,
               req_requester_id, req_signal_mode, req_signal_number,
               req_signal_value, req_owner_gone));
         outstanding <= awaited_results.size();
      end
   end

endmodule

FILE: dv/tb_priority_message_queue.sv
// Testbench top for the priority message queue: clock, reset, requests, register writes, verdict.
module tb_priority_message_queue;

   localparam int StallLimit = 1000;
   localparam int PhaseCount = 8;
   localparam int PhaseItems = 180;
   // Mode three has no name of its own; the block treats it as send and receive.
   localparam logic [1:0] AccessModeThree = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = '0;
   logic [15:0] req_length = '0;
   logic [15:0] req_priority_req = '0;
   logic [15:0] req_payload_tag = '0;
   logic [30:0] req_requester_id = '0;
   logic        req_signal_mode = 1'b0;
   logic [7:0]  req_signal_number = '0;
   logic [63:0] req_signal_value = '0;
   logic        req_owner_gone = 1'b0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [8:0]  rsp_out_length;
   logic [14:0] rsp_out_priority;
   logic [15:0] rsp_out_tag;
   logic [4:0]  rsp_message_count;
   logic        rsp_notify_fire;
   logic [30:0] rsp_notify_target;
   logic [7:0]  rsp_notify_signal;
   logic [63:0] rsp_notify_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int mismatches;
   int outstanding;
   int idle_pct = 0;
   int size_lim = pmq_pkg::MaxMessageBytesDefault;
   int quiet_cycles = 0;

   int         phase_max  [PhaseCount] = '{16, 1, 31, 0, 16, 4, 10, 16};
   int         phase_size [PhaseCount] = '{256, 1, 511, 0, 100, 256, 0, 300};
   logic [1:0] phase_mode [PhaseCount] = '{pmq_pkg::ACCESS_BOTH, AccessModeThree,
                                           pmq_pkg::ACCESS_BOTH, pmq_pkg::ACCESS_BOTH,
                                           pmq_pkg::ACCESS_SEND_ONLY,
                                           pmq_pkg::ACCESS_RECEIVE_ONLY,
                                           pmq_pkg::ACCESS_BOTH, AccessModeThree};
   int         phase_idle [PhaseCount] = '{0, 49, 0, 33, 0, 49, 0, 33};

   priority_message_queue uut (.*);
   pmq_result_checker u_checker (.*);

   always #5 clock = ~clock;

   // Ends the run when nothing has moved on any port for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable && pwrite && pready))
         quiet_cycles <= 0;
      else if (quiet_cycles == StallLimit) begin
         $display("TEST FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic post(input logic [1:0] kind, input logic [15:0] len,
                       input logic [15:0] prio, input logic [15:0] tag,
                       input logic [30:0] id, input logic smode, input logic [7:0] snum,
                       input logic [63:0] sval, input logic gone);
      start             <= 1'b1;
      req_kind          <= kind;
      req_length        <= len;
      req_priority_req  <= prio;
      req_payload_tag   <= tag;
      req_requester_id  <= id;
      req_signal_mode   <= smode;
      req_signal_number <= snum;
      req_signal_value  <= sval;
      req_owner_gone    <= gone;
      do @(posedge clock); while (busy);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Upper bits carry noise, which the block is expected to drop.
   task automatic configure(input int max_msgs, input int msg_size, input logic [1:0] mode);
      write_reg(pmq_pkg::REG_MAX_MESSAGES, ($urandom & ~32'h1F) | 32'(max_msgs));
      write_reg(pmq_pkg::REG_MESSAGE_SIZE, ($urandom & ~32'h1FF) | 32'(msg_size));
      write_reg(pmq_pkg::REG_ACCESS_MODE, ($urandom & ~32'h3) | 32'(mode));
      size_lim = (msg_size > pmq_pkg::MaxMessageBytesDefault)
                 ? pmq_pkg::MaxMessageBytesDefault : msg_size;
   endtask

   // A few owners recur so that cancels and busy registrations often hit.
   function automatic logic [30:0] pick_id();
      case ($urandom_range(7))
         0: return '0;
         1: return 31'($urandom);
         default: return 31'($urandom_range(3, 1));
      endcase
   endfunction

   task automatic post_random();
      int          pick;
      logic [15:0] len;
      logic [15:0] prio;
      logic [7:0]  snum;
      pick = $urandom_range(99);
      if (pick < 8) begin
         post(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 31'($urandom),
              1'($urandom), 8'($urandom), {$urandom, $urandom}, 1'($urandom));
      end else if (pick < 50) begin
         prio = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom_range(32767));
         len = ($urandom_range(9) == 0) ? 16'(size_lim + 1) : 16'($urandom_range(size_lim));
         post(pmq_pkg::KIND_SEND, len, prio, 16'($urandom), pick_id(), 1'($urandom),
              8'($urandom), {$urandom, $urandom}, 1'($urandom));
      end else if (pick < 85) begin
         len = ($urandom_range(9) == 0) ? 16'($urandom_range(size_lim))
                                        : 16'(size_lim + $urandom_range(2));
         post(pmq_pkg::KIND_RECEIVE, len, 16'($urandom), 16'($urandom), pick_id(),
              1'($urandom), 8'($urandom), {$urandom, $urandom}, 1'($urandom));
      end else if (pick < 94) begin
         snum = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(64, 1));
         post(pmq_pkg::KIND_NOTIFY_REG, 16'($urandom), 16'($urandom), 16'($urandom),
              pick_id(), 1'($urandom), snum, {$urandom, $urandom}, $urandom_range(3) == 0);
      end else begin
         post(pmq_pkg::KIND_NOTIFY_CANCEL, 16'($urandom), 16'($urandom), 16'($urandom),
              pick_id(), 1'($urandom), 8'($urandom), {$urandom, $urandom}, 1'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset settings.
      post(pmq_pkg::KIND_RECEIVE, 16'd256, '0, '0, 31'd1, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_NOTIFY_CANCEL, '0, '0, '0, '0, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_NOTIFY_REG, '0, '0, '0, 31'd5, 1'b1, 8'd64, '1, 1'b0);
      post(pmq_pkg::KIND_NOTIFY_REG, '0, '0, '0, 31'd6, 1'b1, 8'd1, '0, 1'b0);
      post(pmq_pkg::KIND_SEND, 16'd256, 16'h7FFF, 16'hFFFF, 31'd5, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_SEND, 16'd1, 16'h8000, 16'h0001, 31'd5, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_SEND, 16'd1, 16'hFFFF, 16'h0002, 31'd5, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_SEND, 16'd257, 16'd3, 16'h0003, 31'd5, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_SEND, 16'hFFFF, 16'd3, 16'h0004, 31'd5, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_SEND, '0, '0, '0, 31'd5, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_SEND, 16'd100, 16'h7FFF, 16'h1234, 31'd5, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_NOTIFY_REG, '0, '0, '0, 31'd7, 1'b1, 8'd0, '0, 1'b0);
      post(pmq_pkg::KIND_NOTIFY_REG, '0, '0, '0, 31'd7, 1'b1, 8'd65, '0, 1'b0);
      post(pmq_pkg::KIND_NOTIFY_REG, '0, '0, '0, 31'd7, 1'b1, 8'd255, '0, 1'b0);
      post(pmq_pkg::KIND_NOTIFY_REG, '0, '0, '0, 31'd7, 1'b0, 8'd255, '1, 1'b0);
      post(pmq_pkg::KIND_NOTIFY_REG, '0, '0, '0, 31'h7FFF_FFFF, 1'b1, 8'd1,
           {$urandom, $urandom}, 1'b0);
      post(pmq_pkg::KIND_RECEIVE, 16'd255, '0, '0, 31'd1, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_RECEIVE, 16'hFFFF, '0, '0, 31'd1, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_RECEIVE, 16'd256, '0, '0, 31'd1, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_RECEIVE, 16'd256, '0, '0, 31'd1, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_RECEIVE, 16'd256, '0, '0, 31'd1, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_NOTIFY_REG, '0, '0, '0, 31'd9, 1'b1, 8'd10, 64'hA5A5, 1'b0);
      post(pmq_pkg::KIND_NOTIFY_REG, '0, '0, '0, 31'd11, 1'b1, 8'd20, 64'h5A5A, 1'b1);
      post(pmq_pkg::KIND_NOTIFY_CANCEL, '0, '0, '0, 31'd9, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_SEND, 16'd8, 16'd9, 16'h0BEE, 31'd11, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_NOTIFY_REG, '0, '0, '0, '0, 1'b1, 8'd3, 64'h3, 1'b0);
      post(pmq_pkg::KIND_RECEIVE, 16'd256, '0, '0, 31'd1, 1'b0, '0, '0, 1'b0);
      post(pmq_pkg::KIND_NOTIFY_REG, '0, '0, '0, '0, 1'b1, 8'd3, 64'h3, 1'b0);
      post(pmq_pkg::KIND_SEND, 16'd8, 16'd9, 16'h0C0C, 31'd1, 1'b0, '0, '0, 1'b0);

      // Random phases, each under its own settings and idling; the queue carries over.
      for (int p = 0; p < PhaseCount; p++) begin
         settle();
         configure(phase_max[p], phase_size[p], phase_mode[p]);
         idle_pct = phase_idle[p];
         repeat (PhaseItems) post_random();
      end

      settle();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
